// ----- hw/rtl/imtm_pkg.sv -----
package imtm_pkg;

  localparam int MAX_VOXELS = 4096;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int ADDR_W     = $clog2(MAX_VOXELS);
  localparam int CNT_W      = $clog2(MAX_VOXELS + 1);
  localparam int WORD_W     = 64;
  localparam int WPOS_W     = $clog2(WORD_W);
  localparam int WIDX_W     = 6;
  localparam int WCNT_W     = CNT_W - WPOS_W;
  localparam int ACC_W      = SUM_W + ADDR_W;
  localparam int LIM_W      = ACC_W + 2;
  localparam int THR1_NUM   = 3;
  localparam int THR1_DEN   = 25;
  localparam int THR3_DEN   = 5;
  localparam int K_W        = $clog2(THR1_DEN * MAX_VOXELS + 1);
  localparam int PROD_W     = K_W + SUM_W;
  localparam int CMP_W      = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_last;
    logic                volume_last;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] mask_word;
    logic [WIDX_W-1:0] word_index;
    logic              word_last;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] nvox;
    logic             ovf;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAX,
    B_GATH1,
    B_GATH2,
    B_MASK,
    B_PUSH
  } back_state_e;

endpackage

// ----- hw/rtl/imtm_ram.sv -----
module imtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/imtm_fifo.sv -----
module imtm_fifo import imtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output logic nempty_o,
  output logic full_o,
  output job_t pop_data_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;

  assign nempty_o   = cnt_q != '0;
  assign full_o     = cnt_q == QCNT_W'(QDEPTH);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("job pushed into full queue");

endmodule

// ----- hw/rtl/imtm_front.sv -----
module imtm_front import imtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  input  logic              hold_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [SUM_W-1:0]  ram_wdata_o,
  output logic              job_push_o,
  output job_t              job_o
);

  logic [SUM_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  logic             fire, sat, close, full, ovf_n;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_c;
  logic [CNT_W-1:0] cnt_n;

  always_comb begin
    fire    = in_valid_i && !hold_i;
    sum_ext = {1'b0, run_q} + (SUM_W + 1)'(in_data_i.sample);
    sat     = sum_ext[SUM_W];
    sum_c   = sat ? '1 : sum_ext[SUM_W-1:0];
    close   = in_data_i.frame_last || in_data_i.volume_last;
    full    = cnt_q == CNT_W'(MAX_VOXELS);
    ovf_n   = ovf_q || sat || (close && full);
    cnt_n   = (close && !full) ? cnt_q + CNT_W'(1) : cnt_q;

    run_d = run_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (fire) begin
      run_d = close ? '0 : sum_c;
      cnt_d = in_data_i.volume_last ? '0 : cnt_n;
      ovf_d = in_data_i.volume_last ? 1'b0 : ovf_n;
    end
  end

  assign in_ready_o  = !hold_i;
  assign ram_we_o    = fire && close && !full;
  assign ram_waddr_o = cnt_q[ADDR_W-1:0];
  assign ram_wdata_o = sum_c;
  assign job_push_o  = fire && in_data_i.volume_last;
  assign job_o.nvox  = cnt_n;
  assign job_o.ovf   = ovf_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ----- hw/rtl/imtm_back.sv -----
module imtm_back import imtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              busy_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [SUM_W-1:0]  rd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o
);

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]  nvox_q, idx_q, end_q, n_q;
  logic              ovf_q, empty_q;
  logic [K_W-1:0]    k_q;
  logic [LIM_W-1:0]  lim_q;
  logic [SUM_W-1:0]  max_q, s2_q;
  logic [ACC_W-1:0]  acc_q;
  logic [WCNT_W-1:0] w_q;
  logic [WORD_W-1:0] word_q;
  logic              v1_q, v2_q;
  logic [WPOS_W-1:0] pos1_q, pos2_q;
  logic [PROD_W-1:0] p2_q;
  logic              out_v_q;
  out_t              out_q;

  logic              in_pass, issue, pass_done, slot_free, last_word, hit;
  logic [CNT_W-1:0]  base, nbase, next_end, first_end;
  logic [CNT_W:0]    base_end, nb_end;

  always_comb begin
    in_pass   = (state_q == B_MAX) || (state_q == B_GATH1) ||
                (state_q == B_GATH2) || (state_q == B_MASK);
    issue     = in_pass && (idx_q != end_q);
    pass_done = in_pass && (idx_q == end_q) && !v1_q && !v2_q;
    slot_free = !out_v_q || out_ready_i;
    base      = {w_q, WPOS_W'(0)};
    base_end  = (CNT_W + 1)'(base) + (CNT_W + 1)'(WORD_W);
    last_word = base_end >= {1'b0, nvox_q};
    nbase     = base_end[CNT_W-1:0];
    nb_end    = (CNT_W + 1)'(nbase) + (CNT_W + 1)'(WORD_W);
    next_end  = (nb_end >= {1'b0, nvox_q}) ? nvox_q : nb_end[CNT_W-1:0];
    first_end = ((CNT_W + 1)'(WORD_W) >= {1'b0, nvox_q}) ? nvox_q : CNT_W'(WORD_W);
    hit       = CMP_W'(p2_q) > CMP_W'(lim_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (job_valid_i) state_d = B_MAX;
      B_MAX:   if (pass_done) state_d = B_GATH1;
      B_GATH1: if (pass_done) state_d = B_GATH2;
      B_GATH2: if (pass_done) state_d = B_MASK;
      B_MASK:  if (pass_done) state_d = B_PUSH;
      B_PUSH: begin
        if (slot_free) begin
          state_d = last_word ? B_IDLE : B_MASK;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = (state_q == B_IDLE) && job_valid_i;
    busy_o    = state_q != B_IDLE;
    rd_en_o   = issue;
    rd_addr_o = idx_q[ADDR_W-1:0];
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if ((state_q == B_PUSH) && slot_free) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            idx_q <= '0;
            end_q <= job_i.nvox;
          end
        end
        B_MAX, B_GATH1: begin
          if (pass_done) begin
            idx_q <= '0;
            end_q <= nvox_q;
          end
        end
        B_GATH2: begin
          if (pass_done) begin
            idx_q <= '0;
            end_q <= first_end;
          end
        end
        B_MASK: ;
        B_PUSH: begin
          if (slot_free && !last_word) begin
            idx_q <= nbase;
            end_q <= next_end;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pos1_q <= idx_q[WPOS_W-1:0];
    end
    if (v1_q) begin
      s2_q   <= rd_data_i;
      p2_q   <= PROD_W'(k_q) * PROD_W'(rd_data_i);
      pos2_q <= pos1_q;
    end
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          nvox_q <= job_i.nvox;
          ovf_q  <= job_i.ovf;
          max_q  <= '0;
        end
      end
      B_MAX: begin
        if (v2_q && (s2_q > max_q)) begin
          max_q <= s2_q;
        end
        if (pass_done) begin
          k_q   <= K_W'(THR1_DEN);
          lim_q <= LIM_W'(max_q) * LIM_W'(THR1_NUM);
          n_q   <= '0;
          acc_q <= '0;
        end
      end
      B_GATH1, B_GATH2: begin
        if (v2_q && hit) begin
          n_q   <= n_q + CNT_W'(1);
          acc_q <= acc_q + ACC_W'(s2_q);
        end
        if (pass_done && (state_q == B_GATH1)) begin
          k_q   <= K_W'(n_q) * K_W'(THR1_DEN);
          lim_q <= LIM_W'(acc_q) * LIM_W'(THR1_NUM);
          n_q   <= '0;
          acc_q <= '0;
        end
        if (pass_done && (state_q == B_GATH2)) begin
          k_q     <= K_W'(n_q) * K_W'(THR3_DEN);
          lim_q   <= LIM_W'(acc_q);
          empty_q <= n_q == '0;
          w_q     <= '0;
          word_q  <= '0;
        end
      end
      B_MASK: begin
        if (v2_q) begin
          word_q[pos2_q] <= hit && !empty_q;
        end
      end
      B_PUSH: begin
        if (slot_free) begin
          out_q.mask_word  <= word_q;
          out_q.word_index <= WIDX_W'(w_q);
          out_q.word_last  <= last_word;
          out_q.overflow   <= ovf_q;
          w_q              <= w_q + WCNT_W'(1);
          word_q           <= '0;
        end
      end
      default: ;
    endcase
  end

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE) |-> !v1_q && !v2_q)
    else $error("read pipeline busy while idle");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> idx_q <= end_q)
    else $error("read index past pass end");

endmodule

// ----- hw/rtl/iterative_mean_threshold_mask.sv -----
// iterative mean threshold mask
// in channel: one time sample per transfer, voxel by voxel with time innermost;
// frame_last closes a voxel, volume_last closes the voxel and the volume.
// while a volume loads, one sample is taken every cycle and each closed voxel
// sum (saturating at 24 bits), up to 4096, is written to a 4096 x 24 voxel store.
// after volume_last the back end runs over the store with one read a cycle:
// a max pass and two gather passes over the n stored voxels, then a mask pass
// over the voxels of each mask word; in_ready_o is low meanwhile.
// out channel: one 64-bit mask word per transfer, word_index counting up,
// word_last on the final word; an empty volume gives one zero word.
// a finished word waits in the output register, the next word is built
// behind it, and a stalled receiver holds the back end at its next word.
// the next volume can start loading once the last word is in the register.
// reset clears the control state and the input running sum; the voxel store is not
// cleared, only entries written in the current volume are ever read.
module iterative_mean_threshold_mask import imtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic              ram_we, rd_en, job_push, job_pop, q_nempty, q_full, back_busy, hold;
  logic [ADDR_W-1:0] ram_waddr, rd_addr;
  logic [SUM_W-1:0]  ram_wdata, rd_data;
  job_t              job_in, job_out;

  assign hold = q_nempty || back_busy;

  imtm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .hold_i      (hold),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  imtm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .pop_i       (job_pop),
    .nempty_o    (q_nempty),
    .full_o      (q_full),
    .pop_data_o  (job_out)
  );

  imtm_ram #(
    .Width (SUM_W),
    .Depth (MAX_VOXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  imtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_nempty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !back_busy && !q_nempty && !q_full)
    else $error("store written while back end reads it");

endmodule

// ----- tb/tb_iterative_mean_threshold_mask.sv -----
module tb_iterative_mean_threshold_mask;
  timeunit 1ns;
  timeprecision 1ps;

  import imtm_pkg::*;

  localparam int unsigned SUM_MAX = (1 << SUM_W) - 1;

  class mask_scoreboard;
    bit [SUM_W-1:0] vox_sum [MAX_VOXELS];
    int unsigned acc;
    int unsigned stored;
    bit ovf_flag;
    out_t expected_words[$];
    int words_made;
    int fails;

    task report(string what, longint unsigned got, longint unsigned want);
      if (fails < 100) begin
        $display("mismatch %s: got %h expected %h", what, got, want);
      end
      fails++;
    endtask

    // count and total of the stored sums s with k * s > lim
    function void tally(longint unsigned k, longint unsigned lim,
                        output longint unsigned tot, output longint unsigned cnt);
      longint unsigned s;
      tot = 0;
      cnt = 0;
      for (int i = 0; i < stored; i++) begin
        s = vox_sum[i];
        if (k * s > lim) begin
          tot += s;
          cnt++;
        end
      end
    endfunction

    function void take_sample(in_t x);
      longint unsigned top, s1, n1, s2, n2, s;
      int nwords;
      int v;
      out_t w;
      acc = acc + x.sample;
      if (acc > SUM_MAX) begin
        acc = SUM_MAX;
        ovf_flag = 1'b1;
      end
      if (x.frame_last || x.volume_last) begin
        if (stored < MAX_VOXELS) begin
          vox_sum[stored] = acc[SUM_W-1:0];
          stored++;
        end else begin
          ovf_flag = 1'b1;
        end
        acc = 0;
      end
      if (!x.volume_last) return;

      top = 0;
      for (int i = 0; i < stored; i++) begin
        if (vox_sum[i] > top) top = vox_sum[i];
      end
      tally(THR1_DEN, THR1_NUM * top, s1, n1);
      s2 = 0;
      n2 = 0;
      if (n1 != 0) tally(THR1_DEN * n1, THR1_NUM * s1, s2, n2);

      nwords = (stored + WORD_W - 1) / WORD_W;
      if (nwords == 0) nwords = 1;
      for (int wi = 0; wi < nwords; wi++) begin
        w.mask_word = '0;
        for (int b = 0; b < WORD_W; b++) begin
          v = wi * WORD_W + b;
          if (n1 != 0 && n2 != 0 && v < stored) begin
            s = vox_sum[v];
            if (THR3_DEN * n2 * s > s2) w.mask_word[b] = 1'b1;
          end
        end
        w.word_index = WIDX_W'(wi);
        w.word_last  = (wi == nwords - 1);
        w.overflow   = ovf_flag;
        expected_words.push_back(w);
        words_made++;
      end
      acc = 0;
      stored = 0;
      ovf_flag = 1'b0;
    endfunction

    task check_word(out_t y);
      out_t e;
      if (expected_words.size() == 0) begin
        report("unexpected mask word", y.mask_word, 0);
        return;
      end
      e = expected_words.pop_front();
      if (y.mask_word !== e.mask_word) report("mask_word", y.mask_word, e.mask_word);
      if (y.word_index !== e.word_index) report("word_index", y.word_index, e.word_index);
      if (y.word_last !== e.word_last) report("word_last", y.word_last, e.word_last);
      if (y.overflow !== e.overflow) report("overflow", y.overflow, e.overflow);
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  mask_scoreboard sb = new();
  bit calm = 1'b0;
  int sent = 0;

  iterative_mean_threshold_mask dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fl,
                             input logic vl);
    in_t x;
    x.sample      = smp;
    x.frame_last  = fl;
    x.volume_last = vl;
    if (!calm && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_sample(x);
    sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int flavor);
    case (flavor)
      0: return SAMPLE_W'($urandom_range(0, 65535));
      1: return SAMPLE_W'($urandom_range(0, 31));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return SAMPLE_W'($urandom_range(0, 65535));
          default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_volume(input int nvox, input int max_frames, input int flavor);
    int nf;
    logic fl, vl;
    for (int v = 0; v < nvox; v++) begin
      nf = $urandom_range(1, max_frames);
      for (int f = 0; f < nf; f++) begin
        vl = (f == nf - 1) && (v == nvox - 1);
        fl = (f == nf - 1) && (!vl || $urandom_range(0, 1) == 1);
        send_sample(pick_sample(flavor), fl, vl);
      end
    end
  endtask

  // result side: check on each transfer, stall at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int vol;
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single voxel at full scale
    send_sample(16'hFFFF, 1'b1, 1'b1);
    // all zero sums, no contributors; volume end closes the open voxel
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b1);
    // mixed sums, multi-frame voxel, volume end without frame end
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    send_sample(16'h5555, 1'b1, 1'b0);
    send_sample(16'h0C00, 1'b1, 1'b0);
    send_sample(16'hAAAA, 1'b0, 1'b1);
    // saturating voxel sum
    for (int i = 0; i < 260; i++) send_sample(16'hFFFF, 1'(i == 259), 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    send_sample(16'hF000, 1'b1, 1'b1);
    // store full: voxels past capacity are dropped
    for (int i = 0; i < MAX_VOXELS + 4; i++) begin
      send_sample(SAMPLE_W'($urandom_range(0, 65535)), 1'b1, 1'(i == MAX_VOXELS + 3));
    end
    // flags must be clear again
    send_sample(16'h1234, 1'b1, 1'b0);
    send_sample(16'h0010, 1'b0, 1'b0);
    send_sample(16'h0020, 1'b1, 1'b1);

    sent = 0;
    vol  = 0;
    while (sent < 210) begin
      calm = (vol >= 8 && vol < 16);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_volume($urandom_range(1, 12), $urandom_range(1, 3), $urandom_range(0, 2));
      end else if (r < 78) begin
        send_volume($urandom_range(40, 140), $urandom_range(1, 2), $urandom_range(0, 2));
      end else if (r < 88) begin
        send_volume($urandom_range(1, 6), $urandom_range(1, 3), 3);
      end else begin
        send_volume($urandom_range(1, 8), 6, 1);
      end
      vol++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
